/* rtl/mft_pkg.sv */
// shared types and constants for the membership failure table
`default_nettype none
package mft_pkg;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned ID_W = 16;
    localparam int unsigned INC_W = 32;
    localparam int unsigned ST_W = 2;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [INC_W-1:0] TIMEOUT_RESET = 32'd3000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 3'd0, CMD_ACK = 3'd1, CMD_SUSPECT = 3'd2, CMD_DEAD = 3'd3,
        CMD_GOSSIP = 3'd4, CMD_JOIN = 3'd5, CMD_QUERY = 3'd6, CMD_NONE = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_ALIVE = 2'd0, ST_SUSPECTED = 2'd1, ST_DEAD = 2'd2, ST_BAD = 2'd3
    } t_mstate;

    typedef enum logic [1:0] {
        STS_DONE = 2'd0, STS_NOT_FOUND = 2'd1, STS_FULL = 2'd2, STS_PRESENT = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_MEMBERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIMEOUT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic scan_clr;  // restart scan index and counters
        logic scan_step; // process one entry
        logic apply;     // apply command to found entry / append
        logic fill_step; // write one initial member
        logic emit;      // latch result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic found;
        logic fill_last;
        logic is_tick;
    } t_sts;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   target_id;
        logic [INC_W-1:0]  incarnation_in;
        logic [ST_W-1:0]   state_in;
        logic [TICK_W-1:0] tick_ms;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [ST_W-1:0]  member_state;
        logic [INC_W-1:0] member_incarnation;
        logic [CNT_W-1:0] alive_total;
        logic [CNT_W-1:0] suspected_count;
        logic [CNT_W-1:0] dead_count;
        logic [CNT_W-1:0] expired_count;
    } t_result;
endpackage
`default_nettype wire

/* rtl/mft_stream_if.sv */
// valid/ready channel carrying one payload
`default_nettype none
interface mft_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/mft_ctrl.sv */
// sequencing state machine for the membership failure table
`default_nettype none
module mft_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    input  wire logic          i_fill_req,
    input  wire mft_pkg::t_sts i_sts,
    output mft_pkg::t_ctl      o_ctl
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_APPLY = 5'b00100,
        S_COUNT = 5'b01000, S_FILL = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // result register frees when taken
    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready = (r_state == S_IDLE) && !i_fill_req;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_fill_req) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_FILL;
                end else if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_FILL: begin
                o_ctl.fill_step = 1'b1;
                if (i_sts.fill_last) n_state = S_IDLE;
            end
            // find entry, or expire suspects on a tick
            S_SCAN: begin
                if (i_sts.scan_last || i_sts.found) begin
                    n_state = S_APPLY;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_APPLY: begin
                o_ctl.apply = 1'b1;
                o_ctl.scan_clr = 1'b1;
                n_state = S_COUNT;
            end
            // count states, then hand over result
            S_COUNT: begin
                if (!i_sts.scan_last) begin
                    o_ctl.scan_step = 1'b1;
                end else if (w_out_free) begin
                    o_ctl.emit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

/* rtl/mft_datapath.sv */
// table memories, scan index, counters and result register
`default_nettype none
module mft_datapath #(
    parameter int unsigned MAX_ENTRIES = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mft_pkg::t_ctl                i_ctl,
    output mft_pkg::t_sts                     o_sts,
    input  wire mft_pkg::t_item               i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [mft_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                              o_fill_req,
    output mft_pkg::t_result                  o_result
);
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned N_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned INC_W = mft_pkg::INC_W;
    localparam int unsigned ST_W = mft_pkg::ST_W;
    localparam int unsigned CW = mft_pkg::CNT_W;
    localparam logic [N_W-1:0] MAX_N = N_W'(MAX_ENTRIES);
    localparam logic [INC_W-1:0] INC_MAX = '1;

    // one entry word: id, state, incarnation, suspicion start
    typedef struct packed {
        logic [mft_pkg::ID_W-1:0] id;
        logic [ST_W-1:0]          st;
        logic [INC_W-1:0]         inc;
        logic [INC_W-1:0]         sus;
    } t_entry;

    t_entry r_mem [MAX_ENTRIES];

    mft_pkg::t_item   r_item;
    mft_pkg::t_result r_result;
    logic [N_W-1:0]   r_count;
    logic [INC_W-1:0] r_time;
    logic [INC_W-1:0] r_timeout;
    logic [N_W-1:0]   r_fill_n;
    logic             r_fill_req;
    logic [N_W-1:0]   r_pos, n_pos;  // scan position, also memory address
    logic             r_found;
    logic [IDX_W-1:0] r_hit;
    t_entry           r_sel;         // copy of the found entry
    t_entry           r_rd;          // registered memory read at r_pos
    logic [CW-1:0]    r_na, r_ns, r_nd, r_exp;

    logic             r_mvalid;
    logic [ST_W-1:0]  r_mst;
    logic [INC_W-1:0] r_minc;
    logic [1:0]       r_sts;

    logic [IDX_W-1:0] w_addr;
    logic [IDX_W-1:0] w_raddr;
    t_entry           w_rd, w_wr;
    logic             w_we;
    logic             w_at_end;
    logic [INC_W-1:0] w_age;
    logic [N_W-1:0]   w_cfg_n;

    function automatic logic [INC_W-1:0] sat_inc(input logic [INC_W-1:0] v);
        sat_inc = (v == INC_MAX) ? v : v + INC_W'(1);
    endfunction

    assign w_at_end = (r_pos >= r_count) || (r_pos >= MAX_N);
    assign w_addr = i_ctl.apply ? (r_found ? r_hit : IDX_W'(r_count)) : IDX_W'(r_pos);
    assign w_rd = i_ctl.apply ? r_sel : r_rd;
    assign w_age = r_time - w_rd.sus;
    assign o_sts.scan_last = w_at_end;
    assign o_sts.found = r_found && !o_sts.is_tick;
    assign o_sts.fill_last = (r_pos + N_W'(1) >= r_fill_n) || (r_fill_n == '0);
    assign o_sts.is_tick = (r_item.cmd == mft_pkg::CMD_TICK);
    assign o_fill_req = r_fill_req;
    assign o_result = r_result;

    // saturate initial member count
    always_comb begin
        w_cfg_n = (32'(i_cfg_data[CW-1:0]) > 32'(MAX_ENTRIES)) ? MAX_N
                                                               : N_W'(i_cfg_data[CW-1:0]);
    end

    // next scan position, also the address of the next read
    always_comb begin
        n_pos = r_pos;
        if (i_ctl.scan_clr) n_pos = '0;
        else if (i_ctl.fill_step || (i_ctl.scan_step && !w_at_end)) n_pos = r_pos + N_W'(1);
    end
    assign w_raddr = IDX_W'(n_pos);

    // entry update for the current cycle
    always_comb begin
        w_we = 1'b0;
        w_wr = w_rd;
        if (i_ctl.fill_step && r_fill_n != '0) begin
            w_we = 1'b1;
            w_wr.id = mft_pkg::ID_W'(r_pos);
            w_wr.st = mft_pkg::ST_ALIVE;
            w_wr.inc = '0;
            w_wr.sus = '0;
        end else if (i_ctl.scan_step && !w_at_end && o_sts.is_tick) begin
            if (w_rd.st == mft_pkg::ST_SUSPECTED && w_age > r_timeout) begin
                w_we = 1'b1;
                w_wr.st = mft_pkg::ST_DEAD;
                w_wr.inc = sat_inc(w_rd.inc);
            end
        end else if (i_ctl.apply && r_found) begin
            case (r_item.cmd)
                mft_pkg::CMD_ACK: begin
                    w_we = 1'b1;
                    if (r_item.incarnation_in > w_rd.inc) w_wr.inc = r_item.incarnation_in;
                    if (w_rd.st == mft_pkg::ST_SUSPECTED) begin
                        w_wr.st = mft_pkg::ST_ALIVE;
                        w_wr.inc = sat_inc(w_wr.inc);
                    end
                end
                mft_pkg::CMD_SUSPECT: begin
                    if (w_rd.st == mft_pkg::ST_ALIVE) begin
                        w_we = 1'b1;
                        w_wr.st = mft_pkg::ST_SUSPECTED;
                        w_wr.sus = r_time;
                        w_wr.inc = sat_inc(w_rd.inc);
                    end
                end
                mft_pkg::CMD_DEAD: begin
                    w_we = 1'b1;
                    w_wr.st = mft_pkg::ST_DEAD;
                    w_wr.inc = sat_inc(w_rd.inc);
                end
                mft_pkg::CMD_GOSSIP: begin
                    if (r_item.state_in != mft_pkg::ST_BAD &&
                        r_item.incarnation_in > w_rd.inc) begin
                        w_we = 1'b1;
                        w_wr.inc = r_item.incarnation_in;
                        w_wr.st = r_item.state_in;
                        if (r_item.state_in == mft_pkg::ST_SUSPECTED) w_wr.sus = r_time;
                    end
                end
                default: w_we = 1'b0;
            endcase
        end else if (i_ctl.apply && r_item.cmd == mft_pkg::CMD_JOIN && r_count < MAX_N) begin
            w_we = 1'b1;
            w_wr.id = r_item.target_id;
            w_wr.st = mft_pkg::ST_ALIVE;
            w_wr.inc = '0;
            w_wr.sus = '0;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wr;
    end

    // registered read, a write to the same entry passes through
    always_ff @(posedge i_clk) begin
        if (w_we && w_addr == w_raddr) r_rd <= w_wr;
        else if (n_pos < MAX_N) r_rd <= r_mem[w_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time <= '0;
            r_timeout <= mft_pkg::TIMEOUT_RESET;
            r_fill_req <= 1'b0;
            r_fill_n <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == mft_pkg::REG_INIT_MEMBERS) begin
                r_fill_req <= 1'b1;
                r_fill_n <= w_cfg_n;
                r_count <= w_cfg_n;
                r_time <= '0;
            end else if (i_cfg_we && i_cfg_idx == mft_pkg::REG_DEAD_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end else begin
                if (i_ctl.scan_clr && r_fill_req) r_fill_req <= 1'b0;
                if (i_ctl.load && i_item.cmd == mft_pkg::CMD_TICK)
                    r_time <= r_time + INC_W'(i_item.tick_ms);
                if (i_ctl.apply && !r_found && r_item.cmd == mft_pkg::CMD_JOIN
                    && r_count < MAX_N)
                    r_count <= r_count + N_W'(1);
            end
        end
    end

    // scan state and counters
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_item <= i_item;
        r_pos <= n_pos;
        if (i_ctl.scan_clr) begin
            r_na <= '0;
            r_ns <= '0;
            r_nd <= '0;
            if (!i_ctl.apply) begin
                r_found <= 1'b0;
                r_exp <= '0;
            end
        end else if (i_ctl.scan_step && !w_at_end) begin
            if (o_sts.is_tick && w_we) r_exp <= r_exp + CW'(1);
            if (!r_found && !o_sts.is_tick && w_rd.id == r_item.target_id) begin
                r_found <= 1'b1;
                r_hit <= IDX_W'(r_pos);
                r_sel <= w_rd;
            end
            // counts use the final state of the table
            if (w_wr.st == mft_pkg::ST_ALIVE) r_na <= r_na + CW'(1);
            else if (w_wr.st == mft_pkg::ST_SUSPECTED) r_ns <= r_ns + CW'(1);
            else if (w_wr.st == mft_pkg::ST_DEAD) r_nd <= r_nd + CW'(1);
        end
    end

    // result, member fields taken from the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            r_mvalid <= 1'b0;
            r_sts <= mft_pkg::STS_DONE;
            if (r_item.cmd == mft_pkg::CMD_JOIN) begin
                if (r_found) begin
                    r_sts <= mft_pkg::STS_PRESENT;
                    r_mvalid <= 1'b1;
                end else if (r_count >= MAX_N) begin
                    r_sts <= mft_pkg::STS_FULL;
                end else begin
                    r_mvalid <= 1'b1;
                end
            end else if (r_item.cmd != mft_pkg::CMD_TICK && r_item.cmd != mft_pkg::CMD_NONE) begin
                if (r_found) r_mvalid <= 1'b1;
                else r_sts <= mft_pkg::STS_NOT_FOUND;
            end
            r_mst <= w_wr.st;
            r_minc <= w_wr.inc;
        end
        if (i_ctl.emit) begin
            r_result.status <= r_sts;
            r_result.member_state <= r_mvalid ? r_mst : '0;
            r_result.member_incarnation <= r_mvalid ? r_minc : '0;
            r_result.alive_total <= r_na;
            r_result.suspected_count <= r_ns;
            r_result.dead_count <= r_nd;
            r_result.expired_count <= o_sts.is_tick ? r_exp : '0;
        end
    end
endmodule
`default_nettype wire

/* rtl/membership_failure_table.sv */
// Membership failure table: cluster membership with suspicion timeout.
// Input channel in_if carries one command item (tick, ack, suspect, dead,
// gossip, join, query, none); output channel out_if returns one result per item
// with the addressed entry and the alive/suspected/dead counts.
// Configuration: write i_cfg_we with i_cfg_idx 0 (initial members, refills
// the table) or 1 (dead timeout in ms).
// Each item passes a find/expire scan over the used entries (one entry per
// cycle), an apply step, and a counting scan over all used entries.
// One item at a time. Writing initial members starts a fill during which
// no item is accepted. Reset empties the table and sets the timeout to 3000.
// A finished result waits in the output register while out_if is stalled;
// the next item is taken meanwhile and held before its own result is
// issued until the register frees.
`default_nettype none
module membership_failure_table #(
    parameter int unsigned MAX_ENTRIES = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    mft_stream_if.sink                         in_if,
    mft_stream_if.source                       out_if,
    input  wire logic                          i_cfg_we,
    input  wire logic [mft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mft_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    mft_pkg::t_ctl w_ctl;
    mft_pkg::t_sts w_sts;
    logic          w_fill_req;

    mft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .o_in_ready  (in_if.ready),
        .i_out_ready (out_if.ready),
        .o_out_valid (out_if.valid),
        .i_fill_req  (w_fill_req),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    mft_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_item     (in_if.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fill_req (w_fill_req),
        .o_result   (out_if.data)
    );
endmodule
`default_nettype wire

/* tb/membership_scoreboard.sv */
// scoreboard class holding the membership table prediction and expected results
`timescale 1ns / 100ps
`default_nettype none

class membership_scoreboard;
    localparam int DEPTH = 32;
    logic [mft_pkg::ID_W-1:0]  ids [DEPTH];
    logic [mft_pkg::ST_W-1:0]  states [DEPTH];
    logic [mft_pkg::INC_W-1:0] incs [DEPTH];
    logic [mft_pkg::INC_W-1:0] susp_start [DEPTH];
    int unsigned               used;
    logic [mft_pkg::INC_W-1:0] now_ms;
    logic [mft_pkg::INC_W-1:0] timeout_ms;
    mft_pkg::t_result          pending_results [$];
    int unsigned               mismatches;
    int unsigned               results_checked;

    function new();
        used = 0;
        now_ms = '0;
        timeout_ms = mft_pkg::TIMEOUT_RESET;
        mismatches = 0;
        results_checked = 0;
    endfunction

    function logic [mft_pkg::INC_W-1:0] bump(logic [mft_pkg::INC_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // register write as seen by the table
    function void write_reg(logic [mft_pkg::CFG_IDX_W-1:0] idx,
                            logic [mft_pkg::CFG_DATA_W-1:0] data);
        int unsigned n;
        if (idx == mft_pkg::REG_INIT_MEMBERS) begin
            n = data[5:0];
            if (n > DEPTH) n = DEPTH;
            for (int i = 0; i < n; i++) begin
                ids[i] = mft_pkg::ID_W'(i);
                states[i] = mft_pkg::ST_ALIVE;
                incs[i] = '0;
                susp_start[i] = '0;
            end
            used = n;
            now_ms = '0;
        end else begin
            timeout_ms = data;
        end
    endfunction

    function int find_id(logic [mft_pkg::ID_W-1:0] id);
        for (int i = 0; i < used; i++)
            if (ids[i] == id) return i;
        return -1;
    endfunction

    // accepted item: update table and queue the expected result
    function void note_item(mft_pkg::t_item it);
        mft_pkg::t_result r;
        int idx;
        r = '0;
        idx = -1;
        case (mft_pkg::t_cmd'(it.cmd))
            mft_pkg::CMD_TICK: begin
                now_ms = now_ms + it.tick_ms;
                for (int i = 0; i < used; i++)
                    if (states[i] == mft_pkg::ST_SUSPECTED &&
                        (now_ms - susp_start[i]) > timeout_ms) begin
                        states[i] = mft_pkg::ST_DEAD;
                        incs[i] = bump(incs[i]);
                        r.expired_count++;
                    end
            end
            mft_pkg::CMD_JOIN: begin
                idx = find_id(it.target_id);
                if (idx >= 0) r.status = mft_pkg::STS_PRESENT;
                else if (used >= DEPTH) r.status = mft_pkg::STS_FULL;
                else begin
                    idx = used;
                    ids[idx] = it.target_id;
                    states[idx] = mft_pkg::ST_ALIVE;
                    incs[idx] = '0;
                    susp_start[idx] = '0;
                    used++;
                end
            end
            mft_pkg::CMD_NONE: ;
            default: begin
                idx = find_id(it.target_id);
                if (idx < 0) r.status = mft_pkg::STS_NOT_FOUND;
                else case (mft_pkg::t_cmd'(it.cmd))
                    mft_pkg::CMD_ACK: begin
                        if (it.incarnation_in > incs[idx]) incs[idx] = it.incarnation_in;
                        if (states[idx] == mft_pkg::ST_SUSPECTED) begin
                            states[idx] = mft_pkg::ST_ALIVE;
                            incs[idx] = bump(incs[idx]);
                        end
                    end
                    mft_pkg::CMD_SUSPECT: if (states[idx] == mft_pkg::ST_ALIVE) begin
                        states[idx] = mft_pkg::ST_SUSPECTED;
                        susp_start[idx] = now_ms;
                        incs[idx] = bump(incs[idx]);
                    end
                    mft_pkg::CMD_DEAD: begin
                        states[idx] = mft_pkg::ST_DEAD;
                        incs[idx] = bump(incs[idx]);
                    end
                    mft_pkg::CMD_GOSSIP: if (it.state_in <= mft_pkg::ST_DEAD &&
                                             it.incarnation_in > incs[idx]) begin
                        incs[idx] = it.incarnation_in;
                        states[idx] = it.state_in;
                        if (it.state_in == mft_pkg::ST_SUSPECTED) susp_start[idx] = now_ms;
                    end
                    default: ;
                endcase
            end
        endcase
        if (idx >= 0) begin
            r.member_state = states[idx];
            r.member_incarnation = incs[idx];
        end
        for (int i = 0; i < used; i++)
            if (states[i] == mft_pkg::ST_ALIVE) r.alive_total++;
            else if (states[i] == mft_pkg::ST_SUSPECTED) r.suspected_count++;
            else if (states[i] == mft_pkg::ST_DEAD) r.dead_count++;
        pending_results.push_back(r);
    endfunction

    // one line per mismatch, and count it
    task report(string msg);
        $display("mismatch %s", msg);
        mismatches++;
    endtask

    task flag(string what, logic [31:0] got, logic [31:0] want);
        report($sformatf("%s: got %0d expected %0d", what, got, want));
    endtask

    // compare one result transfer against the oldest expectation
    task check_result(mft_pkg::t_result got);
        mft_pkg::t_result w;
        if (pending_results.size() == 0) begin
            report("result: nothing expected");
            return;
        end
        w = pending_results.pop_front();
        results_checked++;
        if (got.status != w.status) flag("status", got.status, w.status);
        if (got.member_state != w.member_state) flag("state", got.member_state, w.member_state);
        if (got.member_incarnation != w.member_incarnation)
            flag("incarnation", got.member_incarnation, w.member_incarnation);
        if (got.alive_total != w.alive_total) flag("alive", got.alive_total, w.alive_total);
        if (got.suspected_count != w.suspected_count)
            flag("suspected", got.suspected_count, w.suspected_count);
        if (got.dead_count != w.dead_count) flag("dead", got.dead_count, w.dead_count);
        if (got.expired_count != w.expired_count)
            flag("expired", got.expired_count, w.expired_count);
    endtask
endclass
`default_nettype wire

/* tb/tb_top.sv */
// top-level testbench for the membership failure table
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [mft_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [mft_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    mft_stream_if #(.T(mft_pkg::t_item)) in_if ();
    mft_stream_if #(.T(mft_pkg::t_result)) out_if ();

    membership_failure_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(in_if.sink), .out_if(out_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    membership_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_stall_go = 1'b0;
    bit long_stall_done = 1'b0;
    int hold_off_cycles = 0;
    int items_sent = 0;
    bit stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    // monitor: note input transfers and check result transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) sb.note_item(in_if.data);
            if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_if.ready <= 1'b0;
        end else if (long_stall_go && !long_stall_done) begin
            hold_off_cycles <= 600;
            long_stall_done <= 1'b1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(mft_pkg::t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.data <= it;
        in_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic send_cmd(mft_pkg::t_cmd c, logic [mft_pkg::ID_W-1:0] id,
                            logic [mft_pkg::INC_W-1:0] inc,
                            logic [mft_pkg::ST_W-1:0] st, logic [mft_pkg::TICK_W-1:0] tk);
        mft_pkg::t_item it;
        it.cmd = c;
        it.target_id = id;
        it.incarnation_in = inc;
        it.state_in = st;
        it.tick_ms = tk;
        send_item(it);
    endtask

    // wait for all results, let the block settle, then write a register
    task automatic write_reg(logic [mft_pkg::CFG_IDX_W-1:0] idx,
                             logic [mft_pkg::CFG_DATA_W-1:0] data);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random item biased toward ids in the table
    task automatic send_random();
        mft_pkg::t_cmd c;
        logic [mft_pkg::ID_W-1:0] id;
        logic [mft_pkg::INC_W-1:0] inc;
        int r;
        r = $urandom_range(99);
        c = (r < 20) ? mft_pkg::CMD_TICK :
            (r < 97) ? mft_pkg::t_cmd'($urandom_range(1, 6)) : mft_pkg::CMD_NONE;
        id = ($urandom_range(9) < 8) ? mft_pkg::ID_W'($urandom_range(40))
                                     : mft_pkg::ID_W'($urandom);
        case ($urandom_range(3))
            0: inc = $urandom;
            1: inc = 32'hFFFF_FFF0 + $urandom_range(15);
            default: inc = $urandom_range(8);
        endcase
        send_cmd(c, id, inc, mft_pkg::ST_W'($urandom_range(3)),
                 ($urandom_range(4) == 0) ? mft_pkg::TICK_W'($urandom)
                                          : mft_pkg::TICK_W'($urandom_range(1500)));
    endtask

    task automatic random_phase(int n, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (n) send_random();
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and special cases
        send_cmd(mft_pkg::CMD_JOIN, 16'hFFFF, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_JOIN, 16'hFFFF, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_QUERY, 16'h1234, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_NONE, 16'hFFFF, '1, mft_pkg::ST_BAD, '1);
        write_reg(mft_pkg::REG_INIT_MEMBERS, 32);
        write_reg(mft_pkg::REG_DEAD_TIMEOUT, 0);
        send_cmd(mft_pkg::CMD_JOIN, 16'd77, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_SUSPECT, 0, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_SUSPECT, 0, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_ACK, 0, 5, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_SUSPECT, 1, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_TICK, 0, 0, mft_pkg::ST_ALIVE, 16'hFFFF);
        send_cmd(mft_pkg::CMD_GOSSIP, 2, '1, mft_pkg::ST_BAD, 0);
        send_cmd(mft_pkg::CMD_GOSSIP, 2, '1, mft_pkg::ST_SUSPECTED, 0);
        send_cmd(mft_pkg::CMD_GOSSIP, 2, '1, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_ACK, 2, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_DEAD, 2, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_DEAD, 3, 32'hFFFF_FFFE, mft_pkg::ST_DEAD, 0);
        send_cmd(mft_pkg::CMD_GOSSIP, 4, 32'hFFFF_FFFE, mft_pkg::ST_DEAD, 0);
        send_cmd(mft_pkg::CMD_DEAD, 4, 0, mft_pkg::ST_ALIVE, 0);
        send_cmd(mft_pkg::CMD_DEAD, 4, 0, mft_pkg::ST_ALIVE, 0);
        write_reg(mft_pkg::REG_INIT_MEMBERS, 63);
        write_reg(mft_pkg::REG_DEAD_TIMEOUT, '1);
        send_cmd(mft_pkg::CMD_SUSPECT, 5, 0, mft_pkg::ST_ALIVE, 0);
        repeat (3) send_cmd(mft_pkg::CMD_TICK, 0, 0, mft_pkg::ST_ALIVE, 16'hFFFF);

        // random phases across settings
        write_reg(mft_pkg::REG_INIT_MEMBERS, 0);
        write_reg(mft_pkg::REG_DEAD_TIMEOUT, 3000);
        random_phase(350, 38, 67);
        write_reg(mft_pkg::REG_INIT_MEMBERS, 20);
        write_reg(mft_pkg::REG_DEAD_TIMEOUT, 800);
        random_phase(350, 67, 38);
        write_reg(mft_pkg::REG_INIT_MEMBERS, 32);
        write_reg(mft_pkg::REG_DEAD_TIMEOUT, 0);
        // long receiver hold-off while items keep coming
        long_stall_go = 1'b1;
        random_phase(350, 0, 0);
        write_reg(mft_pkg::REG_INIT_MEMBERS, 1);
        write_reg(mft_pkg::REG_DEAD_TIMEOUT, 50000);
        random_phase(350, 0, 0);
        stim_done = 1'b1;
    end

    // wind-down and verdict
    initial begin
        wait (stim_done);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("run covered %0d items and %0d checked results over four settings",
                 items_sent, sb.results_checked);
        $display("mismatches counted: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // timeout guard
    initial begin
        #20ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
